>>> rtl/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg - shared types for the point-in-convex-polygon test
// Vertex layout, command codes and the status group of the cross-product unit.
// ----------------------------------------------------------------------------
package pic_pkg;

   localparam int VcountW     = 9;
   localparam int MinVertices = 3;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef logic signed [31:0] coord_type;

   // x in the low word, y in the high word
   typedef struct packed {
      coord_type y;
      coord_type x;
   } vertex_type;

   // sign of a cross product: neither neg nor pos means zero
   typedef struct packed {
      logic busy;
      logic done;
      logic neg;
      logic pos;
   } cross_status_type;

endpackage

>>> rtl/point_in_convex_test.sv
// ----------------------------------------------------------------------------
// point_in_convex_test - point in convex polygon by fan binary search
// Holds up to MAX_VERTICES counterclockwise vertices and answers point
// queries: inside or on the boundary gives 1.
// ----------------------------------------------------------------------------
//   channel  dir  handshake                 payload
//   req      in   req_valid / req_stall     command, vertex_index, point_x/y
//   rsp      out  rsp_valid / rsp_stall     inside_res
//   csr      in   csr_wr_en                 csr_wr_data (vertex_count)
//
// A vertex write gives no result. A query makes k = ceil(log2(n-2)) search
// steps; every cross product goes through the one shared multiplier twice,
// after the vertex it needs is read from RAM.
// Reset is synchronous and clears control only; vertex RAM is undefined
// until written. req_stall is high for the whole query; a finished result
// waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module point_in_convex_test import pic_pkg::*; #(
   parameter int MAX_VERTICES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_command,
   input  logic [7:0]          req_vertex_index,
   input  logic signed [31:0]  req_point_x,
   input  logic signed [31:0]  req_point_y,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_inside_res,
   input  logic                csr_wr_en,
   input  logic [VcountW-1:0]  csr_wr_data
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int NW = $clog2(MAX_VERTICES + 1);
   localparam int CW = (NW > VcountW) ? NW : VcountW;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_PIV   = 4'd1;
   localparam logic [3:0] ST_F1    = 4'd2;
   localparam logic [3:0] ST_W1    = 4'd3;
   localparam logic [3:0] ST_W2    = 4'd4;
   localparam logic [3:0] ST_BS_RD = 4'd5;
   localparam logic [3:0] ST_BS_W  = 4'd6;
   localparam logic [3:0] ST_FIN_A = 4'd7;
   localparam logic [3:0] ST_FIN_B = 4'd8;
   localparam logic [3:0] ST_FIN_W = 4'd9;
   localparam logic [3:0] ST_DONE  = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic [VcountW-1:0] vcount_ff;
   logic               rsp_valid_ff;
   logic               rsp_inside_ff;
   logic               res_ff;
   coord_type          px_ff, py_ff;
   vertex_type         pivot_ff;
   logic [AW-1:0]      last_ff, lo_ff, hi_ff, mid_ff;

   logic               req_acc;
   logic [CW-1:0]      vc_ext, n_clamp;
   logic [AW-1:0]      last_val;
   logic [AW-1:0]      lo_nx, hi_nx, mid_nx, span;
   logic [AW:0]        sum;

   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   vertex_type         ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   vertex_type         ram_rd_data;

   logic               turn_start;
   cross_status_type   turn_status;
   logic               piv_ld, srch_ld, res_ld, res_val, out_ld;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;

   // vertex count in use, clamped to [3, MAX_VERTICES]
   always_comb begin
      vc_ext = CW'(vcount_ff);
      priority if (vc_ext < CW'(MinVertices)) begin
         n_clamp = CW'(MinVertices);
      end else if (vc_ext > CW'(MAX_VERTICES)) begin
         n_clamp = CW'(MAX_VERTICES);
      end else begin
         n_clamp = vc_ext;
      end
      last_val = AW'(n_clamp - CW'(1));
   end

   assign ram_wr_en   = req_acc && (req_command == CMD_WRITE)
                        && (32'(req_vertex_index) < MAX_VERTICES);
   assign ram_wr_addr = AW'(req_vertex_index);
   assign ram_wr_data = '{y: req_point_y, x: req_point_x};

   pic_ram #(
      .WIDTH ($bits(vertex_type)),
      .DEPTH (MAX_VERTICES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pic_cross u_cross (
      .clock  (clock),
      .reset  (reset),
      .start  (turn_start),
      .org    (pivot_ff),
      .tip    (ram_rd_data),
      .pt_x   (px_ff),
      .pt_y   (py_ff),
      .status (turn_status)
   );

   // next search window: the first fan wedge, or one halving step
   always_comb begin
      if (state_ff == ST_W2) begin
         lo_nx = AW'(1);
         hi_nx = last_ff;
      end else begin
         lo_nx = turn_status.neg ? lo_ff  : mid_ff;
         hi_nx = turn_status.neg ? mid_ff : hi_ff;
      end
      span   = hi_nx - lo_nx;
      sum    = {1'b0, lo_nx} + {1'b0, hi_nx};
      mid_nx = sum[AW:1];
   end

   always_comb begin
      state_in    = state_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      turn_start  = 1'b0;
      piv_ld      = 1'b0;
      srch_ld     = 1'b0;
      res_ld      = 1'b0;
      res_val     = 1'b0;
      out_ld      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_command == CMD_QUERY) begin
               ram_rd_en = 1'b1;
               state_in  = ST_PIV;
            end
         end
         ST_PIV: begin
            piv_ld      = 1'b1;
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(1);
            state_in    = ST_F1;
         end
         ST_F1: begin
            turn_start  = 1'b1;
            ram_rd_en   = 1'b1;
            ram_rd_addr = last_ff;
            state_in    = ST_W1;
         end
         ST_W1: begin
            if (turn_status.done) begin
               if (turn_status.neg) begin
                  res_ld   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  turn_start = 1'b1;
                  state_in   = ST_W2;
               end
            end
         end
         ST_W2, ST_BS_W: begin
            if (turn_status.done) begin
               if (state_ff == ST_W2 && turn_status.pos) begin
                  res_ld   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  srch_ld   = 1'b1;
                  ram_rd_en = 1'b1;
                  if (span > AW'(1)) begin
                     ram_rd_addr = mid_nx;
                     state_in    = ST_BS_RD;
                  end else begin
                     ram_rd_addr = lo_nx;
                     state_in    = ST_FIN_A;
                  end
               end
            end
         end
         ST_BS_RD: begin
            turn_start = 1'b1;
            state_in   = ST_BS_W;
         end
         ST_FIN_A: begin
            // edge origin replaces the pivot from here on
            piv_ld      = 1'b1;
            ram_rd_en   = 1'b1;
            ram_rd_addr = lo_ff + AW'(1);
            state_in    = ST_FIN_B;
         end
         ST_FIN_B: begin
            turn_start = 1'b1;
            state_in   = ST_FIN_W;
         end
         ST_FIN_W: begin
            if (turn_status.done) begin
               res_ld   = 1'b1;
               res_val  = !turn_status.neg;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_ld   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         vcount_ff    <= VcountW'(MinVertices);
      end else begin
         state_ff <= state_in;
         if (out_ld) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            vcount_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         px_ff   <= req_point_x;
         py_ff   <= req_point_y;
         last_ff <= last_val;
      end
      if (piv_ld) begin
         pivot_ff <= ram_rd_data;
      end
      if (srch_ld) begin
         lo_ff  <= lo_nx;
         hi_ff  <= hi_nx;
         mid_ff <= mid_nx;
      end
      if (res_ld) begin
         res_ff <= res_val;
      end
      if (out_ld) begin
         rsp_inside_ff <= res_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

`ifndef SYNTHESIS
   a_turn_start_idle: assert property (@(posedge clock) disable iff (reset)
      turn_start |-> !turn_status.busy)
      else $error("cross unit started while busy");

   a_wr_only_idle: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_IDLE))
      else $error("vertex write during a query");

   a_sign_excl: assert property (@(posedge clock) disable iff (reset)
      turn_status.done |-> !(turn_status.neg && turn_status.pos))
      else $error("cross sign both negative and positive");

   a_window_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BS_RD) |-> (lo_ff < mid_ff) && (mid_ff < hi_ff))
      else $error("search probe outside its window");
`endif

endmodule

>>> rtl/pic_ram.sv
// ----------------------------------------------------------------------------
// pic_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without rd_en.
// ----------------------------------------------------------------------------
module pic_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/pic_cross.sv
// ----------------------------------------------------------------------------
// pic_cross - exact sign of the cross product (tip - org) x (pt - org)
// Sign-magnitude differences, one shared 32x32 multiplier used twice, then a
// 64-bit magnitude compare. Result and done follow the MUL1, MUL2 and CMP phases.
// ----------------------------------------------------------------------------
module pic_cross import pic_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  vertex_type       org,
   input  vertex_type       tip,
   input  coord_type        pt_x,
   input  coord_type        pt_y,
   output cross_status_type status
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL1 = 2'd1;
   localparam logic [1:0] PH_MUL2 = 2'd2;
   localparam logic [1:0] PH_CMP  = 2'd3;

   logic [1:0]  ph_ff, ph_in;
   logic        done_ff;
   logic        neg_ff, pos_ff;
   logic [31:0] mag_a_ff, mag_b_ff, mag_c_ff, mag_d_ff;
   logic        sgn_a_ff, sgn_b_ff, sgn_c_ff, sgn_d_ff;
   logic [63:0] prod1_ff, prod2_ff;
   logic [32:0] sm_a, sm_b, sm_c, sm_d;
   logic [31:0] mul_l, mul_r;
   logic [63:0] mul_p;
   logic        n1, n2, cmp_neg, cmp_pos;

   // {sign, |a - b|}; the magnitude always fits 32 bits
   function automatic logic [32:0] sub_mag(input coord_type a, input coord_type b);
      logic [32:0] d;
      logic [32:0] n;
      d = {a[31], a} - {b[31], b};
      n = -d;
      return d[32] ? {1'b1, n[31:0]} : {1'b0, d[31:0]};
   endfunction

   assign sm_a = sub_mag(tip.x, org.x);
   assign sm_d = sub_mag(pt_y, org.y);
   assign sm_b = sub_mag(tip.y, org.y);
   assign sm_c = sub_mag(pt_x, org.x);

   assign mul_l = (ph_ff == PH_MUL1) ? mag_a_ff : mag_b_ff;
   assign mul_r = (ph_ff == PH_MUL1) ? mag_d_ff : mag_c_ff;
   assign mul_p = mul_l * mul_r;

   always_comb begin
      unique case (ph_ff)
         PH_IDLE: ph_in = start ? PH_MUL1 : PH_IDLE;
         PH_MUL1: ph_in = PH_MUL2;
         PH_MUL2: ph_in = PH_CMP;
         PH_CMP:  ph_in = PH_IDLE;
         default: ph_in = PH_IDLE;
      endcase
   end

   // sign of a*d - b*c from the two signed magnitudes
   always_comb begin
      n1 = (prod1_ff != '0) && (sgn_a_ff ^ sgn_d_ff);
      n2 = (prod2_ff != '0) && (sgn_b_ff ^ sgn_c_ff);
      priority if (n1 != n2) begin
         cmp_neg = n1;
         cmp_pos = !n1;
      end else if (prod1_ff == prod2_ff) begin
         cmp_neg = 1'b0;
         cmp_pos = 1'b0;
      end else if (!n1) begin
         cmp_pos = prod1_ff > prod2_ff;
         cmp_neg = !cmp_pos;
      end else begin
         cmp_neg = prod1_ff > prod2_ff;
         cmp_pos = !cmp_neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= PH_IDLE;
         done_ff <= 1'b0;
      end else begin
         ph_ff   <= ph_in;
         done_ff <= (ph_ff == PH_CMP);
      end
   end

   always_ff @(posedge clock) begin
      if (ph_ff == PH_IDLE && start) begin
         {sgn_a_ff, mag_a_ff} <= sm_a;
         {sgn_b_ff, mag_b_ff} <= sm_b;
         {sgn_c_ff, mag_c_ff} <= sm_c;
         {sgn_d_ff, mag_d_ff} <= sm_d;
      end
      if (ph_ff == PH_MUL1) begin
         prod1_ff <= mul_p;
      end
      if (ph_ff == PH_MUL2) begin
         prod2_ff <= mul_p;
      end
      if (ph_ff == PH_CMP) begin
         neg_ff <= cmp_neg;
         pos_ff <= cmp_pos;
      end
   end

   assign status.busy = (ph_ff != PH_IDLE);
   assign status.done = done_ff;
   assign status.neg  = neg_ff;
   assign status.pos  = pos_ff;

endmodule

>>> tb/sv/point_in_convex_test_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_convex_test_test - self-checking bench for the point-in-polygon block
// Loads convex polygons of assorted sizes and scales, fires point queries at
// them and checks each inside/outside answer against a fan-search predictor
// with exact 66-bit cross products. Sender gaps and receiver stalls are random.
// ----------------------------------------------------------------------------
module point_in_convex_test_test import pic_pkg::*;;

   localparam int        HullDepth    = 256;
   localparam int        RandomItems  = 2000;
   localparam int        QueryLatency = 100;
   localparam int        CycleLimit   = 1_000_000;
   localparam coord_type CoordMin     = 32'sh8000_0000;
   localparam coord_type CoordMax     = 32'sh7fff_ffff;
   localparam real       TwoPi        = 6.283185307179586;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      in_poly;
   } inside_check_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_command;
   logic [7:0]          req_vertex_index;
   logic signed [31:0]  req_point_x;
   logic signed [31:0]  req_point_y;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_inside_res;
   logic                csr_wr_en;
   logic [VcountW-1:0]  csr_wr_data;

   // shadow of the block's state
   vertex_type          hull_shadow [HullDepth];
   logic [VcountW-1:0]  vertex_count_shadow = VcountW'(MinVertices);

   inside_check_type    inside_expect_q [$];
   int                  items_sent   = 0;
   int                  fail_count   = 0;
   int                  cycle_count  = 0;
   int                  hold_request = 0;
   int                  burst_left   = 0;
   real                 poly_cx, poly_cy, poly_r;

   point_in_convex_test #(.MAX_VERTICES(HullDepth)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_vertex_index (req_vertex_index),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_inside_res   (rsp_inside_res),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic int active_vertices();
      if (vertex_count_shadow < MinVertices) return MinVertices;
      if (vertex_count_shadow > HullDepth) return HullDepth;
      return int'(vertex_count_shadow);
   endfunction

   // sign of (a - o) x (p - o), exact
   function automatic int turn_sign(vertex_type o, vertex_type a, coord_type px,
                                    coord_type py);
      logic signed [32:0] ax, ay, qx, qy;
      logic signed [65:0] lhs, rhs;
      ax  = $signed(a.x) - $signed(o.x);
      ay  = $signed(a.y) - $signed(o.y);
      qx  = px - $signed(o.x);
      qy  = py - $signed(o.y);
      lhs = ax * qy;
      rhs = ay * qx;
      if (lhs > rhs) return 1;
      if (lhs < rhs) return -1;
      return 0;
   endfunction

   function automatic logic predict_inside(coord_type px, coord_type py);
      int         n, lo, hi, mid;
      vertex_type pivot;
      n     = active_vertices();
      pivot = hull_shadow[0];
      if (turn_sign(pivot, hull_shadow[1], px, py) < 0) return 1'b0;
      if (turn_sign(pivot, hull_shadow[n-1], px, py) > 0) return 1'b0;
      lo = 1;
      hi = n - 1;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (turn_sign(pivot, hull_shadow[mid], px, py) >= 0) lo = mid;
         else hi = mid;
      end
      return turn_sign(hull_shadow[lo], hull_shadow[lo+1], px, py) >= 0;
   endfunction

   // ---------------------------------------------------------------- helpers

   function automatic real unit_random();
      return real'($urandom) / 4294967296.0;
   endfunction

   function automatic coord_type to_coord(real v);
      if (v >= 2147483647.0) return CoordMax;
      if (v <= -2147483648.0) return CoordMin;
      return coord_type'($rtoi(v));
   endfunction

   function automatic coord_type pick_extreme();
      case ($urandom_range(0, 3))
         0: return CoordMin;
         1: return CoordMax;
         2: return 32'sd0;
         default: return -32'sd1;
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(logic cmd, logic [7:0] slot, coord_type px, coord_type py);
      inside_check_type want;
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_vertex_index <= slot;
      req_point_x      <= px;
      req_point_y      <= py;
      do @(posedge clock); while (req_stall);
      if (cmd == CMD_WRITE) begin
         hull_shadow[slot] = '{y: py, x: px};
      end else begin
         want.x       = px;
         want.y       = py;
         want.in_poly = predict_inside(px, py);
         inside_expect_q.push_back(want);
      end
      items_sent++;
      @(negedge clock);
   endtask

   // sender bursts with random gaps, now and then a long unbroken stretch
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (inside_expect_q.size() != 0) @(negedge clock);
      repeat (QueryLatency) @(negedge clock);
   endtask

   task automatic write_vertex_count(logic [VcountW-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      vertex_count_shadow = value;
   endtask

   // counterclockwise vertices on a jittered circle, clamped to the coordinate range
   task automatic load_polygon(int count);
      real       base, ang_step, ang;
      coord_type vx, vy;
      case ($urandom_range(0, 3))
         0: poly_r = real'($urandom_range(10, 1000));
         1: poly_r = real'($urandom_range(10_000, 10_000_000));
         2: poly_r = real'($urandom_range(100_000_000, 1_000_000_000));
         default: poly_r = real'($urandom_range(1_500_000_000, 2_147_483_647)) * 1.4;
      endcase
      poly_cx  = real'($signed($urandom)) * 0.5;
      poly_cy  = real'($signed($urandom)) * 0.5;
      base     = unit_random() * TwoPi;
      ang_step = TwoPi / count;
      for (int i = 0; i < count; i++) begin
         ang = base + ang_step * (i + 0.9 * unit_random());
         vx  = to_coord(poly_cx + poly_r * $cos(ang));
         vy  = to_coord(poly_cy + poly_r * $sin(ang));
         send_item(CMD_WRITE, 8'(i), vx, vy);
         pace();
      end
   endtask

   task automatic random_query_point(output coord_type px, output coord_type py);
      int                 n, k;
      logic signed [32:0] sx, sy;
      n = active_vertices();
      case ($urandom_range(0, 9))
         6: begin
            k  = $urandom_range(0, n - 1);
            px = hull_shadow[k].x;
            py = hull_shadow[k].y;
         end
         7: begin
            // edge midpoint, rounded down: right on or next to the boundary
            k  = $urandom_range(0, n - 1);
            sx = $signed(hull_shadow[k].x) + $signed(hull_shadow[(k+1)%n].x);
            sy = $signed(hull_shadow[k].y) + $signed(hull_shadow[(k+1)%n].y);
            px = sx[32:1];
            py = sy[32:1];
         end
         8: begin
            px = $urandom;
            py = $urandom;
         end
         9: begin
            px = pick_extreme();
            py = pick_extreme();
         end
         default: begin
            px = to_coord(poly_cx + poly_r * 1.3 * (2.0 * unit_random() - 1.0));
            py = to_coord(poly_cy + poly_r * 1.3 * (2.0 * unit_random() - 1.0));
         end
      endcase
   endtask

   // ---------------------------------------------------------------- tests

   // reset count of three, triangle spanning the whole coordinate range
   task automatic test_extreme_triangle();
      send_item(CMD_WRITE, 8'd0, CoordMin, CoordMin);
      send_item(CMD_WRITE, 8'd1, CoordMax, CoordMin);
      send_item(CMD_WRITE, 8'd2, CoordMax, CoordMax);
      send_item(CMD_WRITE, 8'd255, -32'sd1, CoordMax);
      send_item(CMD_QUERY, 8'd0, CoordMin, CoordMin);
      send_item(CMD_QUERY, 8'd255, CoordMax, CoordMin);
      send_item(CMD_QUERY, 8'd7, CoordMax, CoordMax);
      send_item(CMD_QUERY, 8'd0, CoordMin, CoordMax);
      send_item(CMD_QUERY, 8'd0, 32'sd0, -32'sd1);
      send_item(CMD_QUERY, 8'd0, CoordMax, 32'sd0);
      send_item(CMD_QUERY, 8'd0, 32'sd0, 32'sd0);
      send_item(CMD_QUERY, 8'd0, -32'sd1, CoordMin);
   endtask

   // counts below three clamp; repeated and collinear vertices
   task automatic test_degenerate_polygon();
      wait_for_idle();
      write_vertex_count(0);
      repeat (3) send_item(CMD_WRITE, 8'($urandom_range(0, 2)), 32'sd5, -32'sd7);
      send_item(CMD_WRITE, 8'd0, 32'sd5, -32'sd7);
      send_item(CMD_WRITE, 8'd1, 32'sd5, -32'sd7);
      send_item(CMD_WRITE, 8'd2, 32'sd5, -32'sd7);
      send_item(CMD_QUERY, 8'd0, 32'sd5, -32'sd7);
      send_item(CMD_QUERY, 8'd0, 32'sd6, -32'sd7);
      send_item(CMD_QUERY, 8'd0, CoordMin, CoordMax);
      wait_for_idle();
      write_vertex_count(2);
      send_item(CMD_WRITE, 8'd0, 32'sd0, 32'sd0);
      send_item(CMD_WRITE, 8'd1, 32'sd10, 32'sd10);
      send_item(CMD_WRITE, 8'd2, 32'sd20, 32'sd20);
      send_item(CMD_QUERY, 8'd0, 32'sd15, 32'sd15);
      send_item(CMD_QUERY, 8'd0, 32'sd30, 32'sd30);
      send_item(CMD_QUERY, 8'd0, 32'sd10, 32'sd11);
   endtask

   // receiver holds off while queries keep coming, then the results drain
   task automatic test_result_backpressure();
      coord_type px, py;
      wait_for_idle();
      write_vertex_count(16);
      load_polygon(16);
      wait_for_idle();
      hold_request = 400;
      repeat (12) begin
         random_query_point(px, py);
         send_item(CMD_QUERY, 8'($urandom_range(0, 255)), px, py);
      end
      wait_for_idle();
   endtask

   task automatic test_random_polygons();
      int                 forced [$];
      int                 stop_at, n, queries;
      logic [VcountW-1:0] setting;
      coord_type          px, py;
      forced  = '{511, 0, 256, 2, 3};
      stop_at = items_sent + RandomItems;
      while (items_sent < stop_at) begin
         if (forced.size() > 0) begin
            setting = VcountW'(forced.pop_front());
         end else begin
            case ($urandom_range(0, 9))
               0:       setting = VcountW'($urandom_range(0, 511));
               1, 2:    setting = VcountW'($urandom_range(17, 64));
               default: setting = VcountW'($urandom_range(3, 16));
            endcase
         end
         wait_for_idle();
         write_vertex_count(setting);
         n = active_vertices();
         load_polygon(n);
         queries = $urandom_range(20, 80);
         repeat (queries) begin
            // stray writes land above the live vertices and must not disturb them
            if (n < HullDepth && $urandom_range(0, 9) == 0) begin
               send_item(CMD_WRITE, 8'($urandom_range(n, HullDepth - 1)), $urandom, $urandom);
            end else begin
               random_query_point(px, py);
               send_item(CMD_QUERY, 8'($urandom_range(0, 255)), px, py);
            end
            pace();
         end
      end
   endtask

   // ---------------------------------------------------------------- processes

   initial begin
      int seg_left, mode, hold_left, period, on_len, tick;
      rsp_stall = 1'b0;
      seg_left  = 0;
      hold_left = 0;
      mode      = 0;
      period    = 4;
      on_len    = 1;
      tick      = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (seg_left == 0) begin
            mode     = $urandom_range(0, 3);
            seg_left = $urandom_range(20, 300);
            period   = $urandom_range(2, 9);
            on_len   = $urandom_range(1, period - 1);
         end
         seg_left--;
         tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ((tick % period) < on_len);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      inside_check_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (inside_expect_q.size() == 0) begin
            fail_count++;
            $display("%0t: stray result, expected none, got inside_res=%0b",
                     $time, rsp_inside_res);
         end else begin
            want = inside_expect_q.pop_front();
            if (rsp_inside_res !== want.in_poly) begin
               fail_count++;
               $display("%0t: inside_res for (%0d, %0d): expected %0b, got %0b",
                        $time, want.x, want.y, want.in_poly, rsp_inside_res);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, cycle_count, inside_expect_q.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_command      = CMD_WRITE;
      req_vertex_index = '0;
      req_point_x      = '0;
      req_point_y      = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_extreme_triangle();
      test_degenerate_polygon();
      test_result_backpressure();
      test_random_polygons();

      wait_for_idle();
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> filelist.f
rtl/pic_pkg.sv
rtl/pic_ram.sv
rtl/pic_cross.sv
rtl/point_in_convex_test.sv
tb/sv/point_in_convex_test_test.sv
